[src/ccl_pkg.sv]
// Shared constants and types for the concept closure engine.
package ccl_pkg;

  // Fixed field widths
  localparam int unsigned ROW_W      = 64;
  localparam int unsigned IDX_W      = 8;
  localparam int unsigned EXT_W      = 9;
  localparam int unsigned OCNT_W     = 9;
  localparam int unsigned ACNT_W     = 7;
  localparam int unsigned CFG_DATA_W = 9;
  localparam int unsigned CFG_IDX_W  = 1;
  // Width for comparing counts and indexes against the object limit (up to 4096)
  localparam int unsigned WIDE_W     = 13;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OBJECT_COUNT    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ATTRIBUTE_COUNT = 1'd1;

  // Commands
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Saturation value of the extent count
  localparam logic [EXT_W-1:0] EXT_MAX = '1;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  // Accumulator control from the sequencer
  typedef struct packed {
    logic clear;
    logic step;
  } acc_ctrl_t;

endpackage

[src/ccl_row_mem.sv]
// Object row store: one write port, one read port with registered read data.
module ccl_row_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int DW    = 64
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/ccl_accum.sv]
// Shared scan unit: subset test of the query against one row, intent AND and extent count.
module ccl_accum #(
  parameter int DW = 64
) (
  input  logic                     clk,
  input  ccl_pkg::acc_ctrl_t       ctrl,
  input  logic [DW-1:0]            init_mask,
  input  logic [DW-1:0]            query,
  input  logic [DW-1:0]            row,
  output logic [DW-1:0]            intent,
  output logic [ccl_pkg::EXT_W-1:0] count
);

  logic match;

  // row holds every queried attribute
  assign match = ((query & ~row) == '0);

  // intent starts as all attributes in use, count saturates
  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      intent <= init_mask;
      count  <= '0;
    end else if (ctrl.step && match) begin
      intent <= intent & row;
      if (count != ccl_pkg::EXT_MAX) begin
        count <= count + 1'b1;
      end
    end
  end

endmodule

[src/concept_closure_engine_core.sv]
// Concept closure engine top level: config registers, scan sequencer and result register.
//
//  channel | signals                                    | direction
//  --------+--------------------------------------------+----------
//  cfg     | cfg_we, cfg_index, cfg_data                | in
//  in      | in_valid/in_stall, cmd, row_index,         | in
//          | row_bits, attr_set                         |
//  out     | out_valid/out_stall, closure_bits,         | out
//          | extent_count                               |
//
// A row write is stored at the edge that accepts it. A closure request reads min(object_count,
// MAX_OBJECTS) rows, one row read per cycle from the single read port of the row store, then
// folds in the last registered read data and loads the result register once the output
// register is not stalled. The next request is taken the cycle after the load.
// Synchronous reset clears the sequencer and sets the config to defaults; the row store is not cleared.
// in_stall is high while a request is in work, during reset, and while a finished
// result waits behind a stalled output register.
module concept_closure_engine_core #(
  parameter int MAX_OBJECTS    = 256,
  parameter int MAX_ATTRIBUTES = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  // configuration
  input  logic                            cfg_we,
  input  logic [ccl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ccl_pkg::CFG_DATA_W-1:0]  cfg_data,
  // input requests
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            cmd,
  input  logic [ccl_pkg::IDX_W-1:0]       row_index,
  input  logic [ccl_pkg::ROW_W-1:0]       row_bits,
  input  logic [ccl_pkg::ROW_W-1:0]       attr_set,
  // results
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [ccl_pkg::ROW_W-1:0]       closure_bits,
  output logic [ccl_pkg::EXT_W-1:0]       extent_count
);

  localparam int AW = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
  localparam int CW = $clog2(MAX_OBJECTS + 1);
  localparam int DW = MAX_ATTRIBUTES;

  ccl_pkg::state_t             state, state_next;
  ccl_pkg::acc_ctrl_t          acc_ctrl;

  logic [ccl_pkg::OCNT_W-1:0]  object_count;
  logic [ccl_pkg::ACNT_W-1:0]  attribute_count;

  logic [DW-1:0]               attr_mask;
  logic [DW-1:0]               mask_q;
  logic [DW-1:0]               query_q;
  logic [CW-1:0]               used_q, used_calc;
  logic [CW-1:0]               scan_cnt, scan_cnt_next;
  logic                        rd_vld, rd_vld_next;
  logic                        rd_en;
  logic                        out_load;

  logic                        in_acc, q_start, wr_en;
  logic [ccl_pkg::WIDE_W-1:0]  idx_wide, oc_wide;

  logic [DW-1:0]               rd_data;
  logic [DW-1:0]               intent;
  logic [ccl_pkg::EXT_W-1:0]   count;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      object_count    <= '0;
      attribute_count <= ccl_pkg::ACNT_W'(64);
    end else if (cfg_we) begin
      case (cfg_index)
        ccl_pkg::REG_OBJECT_COUNT:    object_count    <= cfg_data[ccl_pkg::OCNT_W-1:0];
        ccl_pkg::REG_ATTRIBUTE_COUNT: attribute_count <= cfg_data[ccl_pkg::ACNT_W-1:0];
        default: ;
      endcase
    end
  end

  // attributes in use; counts above DW give all ones
  always_comb begin
    for (int i = 0; i < DW; i++) begin
      attr_mask[i] = (ccl_pkg::ACNT_W'(i) < attribute_count);
    end
  end

  // objects in use, clipped to the store depth
  assign oc_wide   = ccl_pkg::WIDE_W'(object_count);
  assign used_calc = (oc_wide > ccl_pkg::WIDE_W'(MAX_OBJECTS)) ? CW'(MAX_OBJECTS)
                                                               : CW'(oc_wide);

  // input handshake
  assign in_stall = rst || (state != ccl_pkg::ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign q_start  = in_acc && (cmd == ccl_pkg::CMD_QUERY);
  assign idx_wide = ccl_pkg::WIDE_W'(row_index);
  assign wr_en    = in_acc && (cmd == ccl_pkg::CMD_WRITE) &&
                    (idx_wide < ccl_pkg::WIDE_W'(MAX_OBJECTS));

  // query operands captured at request
  always_ff @(posedge clk) begin
    if (q_start) begin
      mask_q  <= attr_mask;
      query_q <= attr_set[DW-1:0] & attr_mask;
      used_q  <= used_calc;
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ccl_pkg::ST_IDLE;
      scan_cnt <= '0;
      rd_vld   <= 1'b0;
    end else begin
      state    <= state_next;
      scan_cnt <= scan_cnt_next;
      rd_vld   <= rd_vld_next;
    end
  end

  // sequencer next state and controls
  always_comb begin
    state_next     = state;
    scan_cnt_next  = scan_cnt;
    rd_vld_next    = 1'b0;
    rd_en          = 1'b0;
    out_load       = 1'b0;
    acc_ctrl.clear = 1'b0;
    acc_ctrl.step  = rd_vld;
    case (state)
      ccl_pkg::ST_IDLE: begin
        if (q_start) begin
          state_next     = ccl_pkg::ST_SCAN;
          scan_cnt_next  = '0;
          acc_ctrl.clear = 1'b1;
        end
      end
      ccl_pkg::ST_SCAN: begin
        if (scan_cnt < used_q) begin
          rd_en         = 1'b1;
          scan_cnt_next = scan_cnt + CW'(1);
          rd_vld_next   = 1'b1;
        end else begin
          // last read data is folded in at this edge
          state_next = ccl_pkg::ST_DONE;
        end
      end
      ccl_pkg::ST_DONE: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = ccl_pkg::ST_IDLE;
        end
      end
      default: state_next = ccl_pkg::ST_IDLE;
    endcase
  end

  ccl_row_mem #(
    .DEPTH (MAX_OBJECTS),
    .AW    (AW),
    .DW    (DW)
  ) u_mem (
    .clk   (clk),
    .we    (wr_en),
    .waddr (idx_wide[AW-1:0]),
    .wdata (row_bits[DW-1:0]),
    .re    (rd_en),
    .raddr (scan_cnt[AW-1:0]),
    .rdata (rd_data)
  );

  ccl_accum #(
    .DW (DW)
  ) u_acc (
    .clk       (clk),
    .ctrl      (acc_ctrl),
    .init_mask (attr_mask),
    .query     (query_q),
    .row       (rd_data),
    .intent    (intent),
    .count     (count)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      closure_bits <= ccl_pkg::ROW_W'(intent | query_q);
      extent_count <= count;
    end
  end

  // checks
  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    (state != ccl_pkg::ST_IDLE) |-> in_stall)
    else $error("request accepted while a closure is in work");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> (scan_cnt < used_q))
    else $error("row read beyond objects in use");

  a_closure_mask: assert property (@(posedge clk) disable iff (rst)
    out_load |=> ((closure_bits & ~ccl_pkg::ROW_W'(mask_q)) == '0))
    else $error("closure holds attributes out of use");

  a_extent_bound: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (ccl_pkg::WIDE_W'(extent_count) <= ccl_pkg::WIDE_W'(used_q)))
    else $error("extent count exceeds objects scanned");

endmodule

[tb/concept_closure_engine_core_test.sv]
// Self-checking testbench for the concept closure engine: row writes, closure queries, config.
module concept_closure_engine_core_test;

  localparam int unsigned OBJ_LIMIT   = 256;
  localparam int unsigned ATTR_LIMIT  = 64;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned LONG_HOLD   = 600;

  typedef struct {
    logic                      op;
    logic [ccl_pkg::IDX_W-1:0] idx;
    logic [ccl_pkg::ROW_W-1:0] bits;
    logic [ccl_pkg::ROW_W-1:0] attrs;
  } request_t;

  typedef struct {
    logic [ccl_pkg::ROW_W-1:0] closure;
    logic [ccl_pkg::EXT_W-1:0] extent;
  } closure_t;

  // Clock, reset and block ports
  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_we = 1'b0;
  logic [ccl_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [ccl_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic                           cmd = ccl_pkg::CMD_WRITE;
  logic [ccl_pkg::IDX_W-1:0]      row_index = '0;
  logic [ccl_pkg::ROW_W-1:0]      row_bits = '0;
  logic [ccl_pkg::ROW_W-1:0]      attr_set = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [ccl_pkg::ROW_W-1:0]      closure_bits;
  logic [ccl_pkg::EXT_W-1:0]      extent_count;

  // Predictor state: context rows and register copies
  logic [ccl_pkg::ROW_W-1:0]  row_model [OBJ_LIMIT];
  logic [ccl_pkg::OCNT_W-1:0] obj_count_cfg = '0;
  logic [ccl_pkg::ACNT_W-1:0] attr_count_cfg = 7'd64;

  request_t pending_requests[$];
  closure_t closure_expected[$];
  request_t next_req;
  closure_t want;

  bit          req_taken = 1'b0;
  bit          steady = 1'b0;
  bit          hold_request = 1'b0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  int unsigned cycle_count = 0;
  int unsigned errors = 0;

  concept_closure_engine_core dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .cmd(cmd), .row_index(row_index),
    .row_bits(row_bits), .attr_set(attr_set),
    .out_valid(out_valid), .out_stall(out_stall),
    .closure_bits(closure_bits), .extent_count(extent_count)
  );

  always #4 clk = ~clk;

  function automatic logic [ccl_pkg::ROW_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // Row contents of varying density
  function automatic logic [ccl_pkg::ROW_W-1:0] rand_row();
    case ($urandom_range(0, 3))
      0: return rand64();
      1: return rand64() | rand64();
      2: return rand64() & rand64();
      default: return rand64() | rand64() | rand64();
    endcase
  endfunction

  function automatic logic [ccl_pkg::ROW_W-1:0] attr_mask();
    int unsigned n;
    n = (attr_count_cfg > ATTR_LIMIT) ? ATTR_LIMIT : attr_count_cfg;
    if (n >= 64) return '1;
    return (64'd1 << n) - 64'd1;
  endfunction

  // Closure of an attribute set over the rows in use
  function automatic closure_t predict_closure(input logic [ccl_pkg::ROW_W-1:0] attrs);
    logic [ccl_pkg::ROW_W-1:0] keep, query, intent, row;
    int unsigned               used, hits;
    closure_t                  res;
    keep   = attr_mask();
    query  = attrs & keep;
    intent = keep;
    used   = (obj_count_cfg > OBJ_LIMIT) ? OBJ_LIMIT : obj_count_cfg;
    hits   = 0;
    for (int unsigned o = 0; o < used; o++) begin
      row = row_model[o[ccl_pkg::IDX_W-1:0]] & keep;
      if ((query & ~row) == '0) begin
        intent &= row;
        hits++;
      end
    end
    if (hits > ccl_pkg::EXT_MAX) hits = 32'(ccl_pkg::EXT_MAX);
    res.closure = (intent | query) & keep;
    res.extent  = hits[ccl_pkg::EXT_W-1:0];
    return res;
  endfunction

  // Query mostly built from stored rows so that extents are not empty
  function automatic logic [ccl_pkg::ROW_W-1:0] make_query();
    int unsigned used, r;
    logic [ccl_pkg::ROW_W-1:0] base;
    used = (obj_count_cfg > OBJ_LIMIT) ? OBJ_LIMIT : obj_count_cfg;
    r = $urandom_range(0, 9);
    if (used == 0 || r == 0) return rand64();
    if (r == 1) return '0;
    if (r == 2) return '1;
    base = row_model[ccl_pkg::IDX_W'($urandom_range(0, used - 1))];
    if (r <= 5) return base & rand64() & rand64();
    if (r == 6) begin
      return base & row_model[ccl_pkg::IDX_W'($urandom_range(0, used - 1))] & rand64();
    end
    if (r == 7) return (base & rand64() & rand64()) | (rand64() & ~attr_mask());
    return base & rand64();
  endfunction

  task automatic add_write(input logic [ccl_pkg::IDX_W-1:0] idx,
                           input logic [ccl_pkg::ROW_W-1:0] bits);
    request_t r;
    r.op = ccl_pkg::CMD_WRITE; r.idx = idx; r.bits = bits; r.attrs = rand64();
    pending_requests.push_back(r);
  endtask

  task automatic add_query(input logic [ccl_pkg::ROW_W-1:0] attrs);
    request_t r;
    r.op = ccl_pkg::CMD_QUERY; r.idx = ccl_pkg::IDX_W'($urandom_range(0, 255));
    r.bits = rand64(); r.attrs = attrs;
    pending_requests.push_back(r);
  endtask

  task automatic write_reg(input logic [ccl_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ccl_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == ccl_pkg::REG_OBJECT_COUNT) obj_count_cfg = data;
    else attr_count_cfg = data[ccl_pkg::ACNT_W-1:0];
  endtask

  // Nothing queued, nothing offered, no result outstanding, then let writes settle
  task automatic wait_idle();
    do @(posedge clk);
    while (pending_requests.size() != 0 || in_valid || closure_expected.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  // Request driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else if (in_valid && !req_taken) begin
      // held until accepted
    end else begin
      req_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_requests.size() > 0) begin
        next_req = pending_requests.pop_front();
        cmd       <= next_req.op;
        row_index <= next_req.idx;
        row_bits  <= next_req.bits;
        attr_set  <= next_req.attrs;
        in_valid  <= 1'b1;
        gap_left = steady ? 0 : pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver stalls
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left = LONG_HOLD;
      out_stall <= 1'b1;
    end else if (steady) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      stall_left = pick_gap();
    end
  end

  // Accepted requests update the predictor
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      req_taken = 1'b1;
      if (cmd == ccl_pkg::CMD_WRITE) row_model[row_index] = row_bits;
      else closure_expected.push_back(predict_closure(attr_set));
    end
  end

  // Result checker and run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("concept_closure_engine_core verification failed");
      $finish;
    end else if (!rst && out_valid && !out_stall) begin
      if (closure_expected.size() == 0) begin
        $display("%0t: unexpected result, closure_bits %h extent_count %0d",
                 $time, closure_bits, extent_count);
        errors++;
      end else begin
        want = closure_expected.pop_front();
        if (closure_bits !== want.closure) begin
          $display("%0t: closure_bits mismatch, expected %h, got %h",
                   $time, want.closure, closure_bits);
          errors++;
        end
        if (extent_count !== want.extent) begin
          $display("%0t: extent_count mismatch, expected %0d, got %0d",
                   $time, want.extent, extent_count);
          errors++;
        end
      end
    end
  end

  // Stimulus sequence
  initial begin
    int unsigned obj, attr, r;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // No objects in use: empty extent gives every attribute
    add_query('1);
    add_query('0);
    // Fill the whole row store so no unwritten row is ever scanned
    add_write(8'd0, '1);
    add_write(8'd1, '0);
    add_write(8'd2, 64'h5555_5555_5555_5555);
    add_write(8'd3, 64'hAAAA_AAAA_AAAA_AAAA);
    for (int unsigned i = 4; i < OBJ_LIMIT; i++) begin
      add_write(i[ccl_pkg::IDX_W-1:0], rand_row());
    end
    wait_idle();

    // Four objects, all attributes
    write_reg(ccl_pkg::REG_OBJECT_COUNT, 9'd4);
    add_query('0);
    add_query(64'h1);
    add_query(64'h2);
    add_query(64'h3);
    add_query('1);
    add_write(8'd1, '1);
    add_query('1);
    wait_idle();

    // Both counts above their limits
    write_reg(ccl_pkg::REG_OBJECT_COUNT, 9'h1FF);
    write_reg(ccl_pkg::REG_ATTRIBUTE_COUNT, 9'h1FF);
    add_query(row_model[8'd5] & rand64());
    add_query('0);
    wait_idle();

    // No attributes in use: closure empty, every object counted
    write_reg(ccl_pkg::REG_OBJECT_COUNT, 9'd256);
    write_reg(ccl_pkg::REG_ATTRIBUTE_COUNT, 9'd0);
    add_query(rand64());
    wait_idle();
    write_reg(ccl_pkg::REG_ATTRIBUTE_COUNT, 9'd1);
    add_query(64'h1);
    add_query(64'hFFFF_FFFF_FFFF_FFFE);
    wait_idle();

    // Random phases over a spread of settings
    for (int unsigned ph = 0; ph < 8; ph++) begin
      r = $urandom_range(0, 11);
      if (ph == 0) obj = 0;
      else if (r == 0) obj = 256;
      else if (r == 1) obj = 511;
      else if (r <= 3) obj = $urandom_range(13, 64);
      else obj = $urandom_range(1, 12);
      if (ph == 1) obj = 3;
      case ($urandom_range(0, 6))
        0: attr = 0;
        1: attr = 1;
        2: attr = $urandom_range(2, 16);
        3: attr = 63;
        4: attr = 64;
        5: attr = $urandom_range(65, 127);
        default: attr = $urandom_range(0, 64);
      endcase
      write_reg(ccl_pkg::REG_OBJECT_COUNT, obj[ccl_pkg::CFG_DATA_W-1:0]);
      write_reg(ccl_pkg::REG_ATTRIBUTE_COUNT, attr[ccl_pkg::CFG_DATA_W-1:0]);
      steady = (ph % 3 == 2);
      // receiver holds off long enough for the engine to back up
      if (ph == 1) hold_request = 1'b1;
      for (int unsigned k = 0; k < 30; k++) begin
        if ($urandom_range(0, 9) < 6) begin
          add_query(make_query());
        end else if ($urandom_range(0, 1) == 0) begin
          add_write(ccl_pkg::IDX_W'($urandom_range(0, 255)), rand_row());
        end else begin
          add_write(ccl_pkg::IDX_W'($urandom_range(0, 255)),
                    row_model[ccl_pkg::IDX_W'($urandom_range(0, 255))] ^
                    (64'd1 << $urandom_range(0, 63)));
        end
      end
      wait_idle();
      steady = 1'b0;
    end

    wait_idle();
    repeat (300) @(posedge clk);
    if (errors == 0) begin
      $display("concept_closure_engine_core verification clean");
    end else begin
      $display("concept_closure_engine_core verification failed");
    end
    $finish;
  end

endmodule
